// File: rtl/nss_pkg.sv
// ----------------------------------------------------------------------------
// nss_pkg
// Shared constants, widths and controller/datapath interface types for the
// nearest segment cell search.
// ----------------------------------------------------------------------------
package nss_pkg;

  localparam int MAX_SEGMENTS = 64;
  localparam int MAX_CELLS    = 255;

  localparam int SEG_AW   = $clog2(MAX_SEGMENTS);   // table address bits
  localparam int SEG_CW   = SEG_AW + 1;             // segment count bits
  localparam int COORD_W  = 24;
  localparam int CLEN_W   = 16;
  localparam int SLEN_W   = 23;
  localparam int CELL_W   = 8;
  localparam int CFG_W    = 7;
  localparam int SLOT_W   = 6;

  localparam int EP_W     = 2 * COORD_W;             // endpoint pair entry
  localparam int GEO_W    = 48;                      // cell geometry entry

  localparam int DIFF_W   = COORD_W + 1;             // end - start, magnitude
  localparam int K_W      = CELL_W + 1;              // 2c+1
  localparam int PROD1_W  = DIFF_W + K_W;            // mag * k
  localparam int PROD2_W  = PROD1_W + CLEN_W;        // mag * k * cell_len
  localparam int NUM_W    = PROD2_W + 1;             // plus segment_len
  localparam int DIV_W    = SLEN_W + 1;              // 2 * segment_len
  localparam int DIV_STEPS = NUM_W;
  localparam int DCNT_W   = $clog2(DIV_STEPS);
  localparam int CEN_W    = NUM_W + 2;               // start + signed offset
  localparam int SQ_W     = 2 * DIFF_W - 1;          // squared axis distance
  localparam int DIST_W   = SQ_W + 1;

  localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  typedef struct packed {
    logic load_wr;      // write one table entry
    logic probe_ld;     // capture query point, clear best, clear segment count
    logic seg_ld;       // capture table entry, clear cell count
    logic seg_inc;
    logic zero_center;
    logic mul1;
    logic mul2;         // also seeds the dividers
    logic div_step;
    logic center;
    logic sq;
    logic cmp;
    logic cell_inc;
    logic res_ld;
  } nss_cmd_t;

  typedef struct packed {
    logic nseg_zero;
    logic rd_n_zero;
    logic rd_len_zero;
    logic seg_len_zero;
    logic last_seg;
    logic last_cell;
    logic div_last;
  } nss_stat_t;

  typedef enum logic [9:0] {
    ST_IDLE   = 10'b00_0000_0001,
    ST_RD     = 10'b00_0000_0010,
    ST_LATCH  = 10'b00_0000_0100,
    ST_MUL1   = 10'b00_0000_1000,
    ST_MUL2   = 10'b00_0001_0000,
    ST_DIV    = 10'b00_0010_0000,
    ST_CENTER = 10'b00_0100_0000,
    ST_SQ     = 10'b00_1000_0000,
    ST_CMP    = 10'b01_0000_0000,
    ST_FINISH = 10'b10_0000_0000
  } nss_state_t;

endpackage

// File: rtl/nearest_segment_cell_search.sv
// ----------------------------------------------------------------------------
// nearest_segment_cell_search
// Segment table with a nearest cell center query, built as a controller and
// a datapath.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  in_     | in_valid / in_stall  | req_type, segment_slot, segment fields, probe
//  out_    | out_valid / out_stall| found, best_segment, best_cell_index
//  cfg_    | cfg_valid / cfg_ready| segments_in_use (cfg_data)
//
// A load transaction is written into the table when it is accepted. A
// query walks every searched segment and places each cell center with the
// two 51-step serial dividers (zero-length segments skip the dividers and
// use a zero center). One item is worked at a time; in_stall is high while
// a query runs. A finished result sits in the output register, so the next
// item is taken while out_stall holds it. Reset is synchronous and clears
// the controller, the valid flags and segments_in_use; the table has no
// reset.
// ----------------------------------------------------------------------------
module nearest_segment_cell_search import nss_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      in_req_type,
  input  logic [SLOT_W-1:0]         in_segment_slot,
  input  logic signed [COORD_W-1:0] in_start_x,
  input  logic signed [COORD_W-1:0] in_start_z,
  input  logic signed [COORD_W-1:0] in_end_x,
  input  logic signed [COORD_W-1:0] in_end_z,
  input  logic [CLEN_W-1:0]         in_cell_len,
  input  logic [SLEN_W-1:0]         in_segment_len,
  input  logic [CELL_W-1:0]         in_cell_total,
  input  logic signed [COORD_W-1:0] in_probe_x,
  input  logic signed [COORD_W-1:0] in_probe_z,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      out_found,
  output logic [SLOT_W-1:0]         out_best_segment,
  output logic [CELL_W-1:0]         out_best_cell_index,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_W-1:0]          cfg_data
);

  nss_cmd_t  cmd;
  nss_stat_t st;

  // Configuration is to be written only while idle; the block does not enforce it: always take it.
  assign cfg_ready = 1'b1;

  nss_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_req_type (in_req_type),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .st          (st),
    .cmd         (cmd)
  );

  nss_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .st                  (st),
    .cfg_data            (cfg_data),
    .cfg_we              (cfg_valid && cfg_ready),
    .in_segment_slot     (in_segment_slot),
    .in_start_x          (in_start_x),
    .in_start_z          (in_start_z),
    .in_end_x            (in_end_x),
    .in_end_z            (in_end_z),
    .in_cell_len         (in_cell_len),
    .in_segment_len      (in_segment_len),
    .in_cell_total       (in_cell_total),
    .in_probe_x          (in_probe_x),
    .in_probe_z          (in_probe_z),
    .out_found           (out_found),
    .out_best_segment    (out_best_segment),
    .out_best_cell_index (out_best_cell_index)
  );

endmodule

// File: rtl/nss_ctrl.sv
// ----------------------------------------------------------------------------
// nss_ctrl
// Sequencer for loads and queries; drives datapath commands and the result
// valid flag.
// ----------------------------------------------------------------------------
module nss_ctrl import nss_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_req_type,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  input  nss_stat_t st,
  output nss_cmd_t  cmd
);

  nss_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       in_acc;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_req_type == REQ_LOAD) begin
            cmd.load_wr = 1'b1;
          end else begin
            cmd.probe_ld = 1'b1;
            state_nxt    = st.nseg_zero ? ST_FINISH : ST_RD;
          end
        end
      end
      ST_RD: state_nxt = ST_LATCH;
      ST_LATCH: begin
        cmd.seg_ld = 1'b1;
        if (st.rd_n_zero) begin
          if (st.last_seg) begin
            state_nxt = ST_FINISH;
          end else begin
            cmd.seg_inc = 1'b1;
            state_nxt   = ST_RD;
          end
        end else if (st.rd_len_zero) begin
          cmd.zero_center = 1'b1;
          state_nxt       = ST_SQ;
        end else begin
          state_nxt = ST_MUL1;
        end
      end
      ST_MUL1: begin
        cmd.mul1  = 1'b1;
        state_nxt = ST_MUL2;
      end
      ST_MUL2: begin
        cmd.mul2  = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (st.div_last) state_nxt = ST_CENTER;
      end
      ST_CENTER: begin
        cmd.center = 1'b1;
        state_nxt  = ST_SQ;
      end
      ST_SQ: begin
        cmd.sq    = 1'b1;
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        cmd.cmp = 1'b1;
        if (st.last_cell) begin
          if (st.last_seg) begin
            state_nxt = ST_FINISH;
          end else begin
            cmd.seg_inc = 1'b1;
            state_nxt   = ST_RD;
          end
        end else begin
          cmd.cell_inc = 1'b1;
          state_nxt    = st.seg_len_zero ? ST_SQ : ST_MUL1;
        end
      end
      ST_FINISH: begin
        if (!out_valid_r || !out_stall) begin
          cmd.res_ld    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// File: rtl/nss_dp.sv
// ----------------------------------------------------------------------------
// nss_dp
// Segment table, cell center arithmetic with two serial dividers, distance
// compare and result register.
// ----------------------------------------------------------------------------
module nss_dp import nss_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  nss_cmd_t                  cmd,
  output nss_stat_t                 st,
  input  logic [CFG_W-1:0]          cfg_data,
  input  logic                      cfg_we,
  input  logic [SLOT_W-1:0]         in_segment_slot,
  input  logic signed [COORD_W-1:0] in_start_x,
  input  logic signed [COORD_W-1:0] in_start_z,
  input  logic signed [COORD_W-1:0] in_end_x,
  input  logic signed [COORD_W-1:0] in_end_z,
  input  logic [CLEN_W-1:0]         in_cell_len,
  input  logic [SLEN_W-1:0]         in_segment_len,
  input  logic [CELL_W-1:0]         in_cell_total,
  input  logic signed [COORD_W-1:0] in_probe_x,
  input  logic signed [COORD_W-1:0] in_probe_z,
  output logic                      out_found,
  output logic [SLOT_W-1:0]         out_best_segment,
  output logic [CELL_W-1:0]         out_best_cell_index
);

  logic [EP_W-1:0]  mem_x [MAX_SEGMENTS];
  logic [EP_W-1:0]  mem_z [MAX_SEGMENTS];
  logic [GEO_W-1:0] mem_g [MAX_SEGMENTS];
  logic [EP_W-1:0]  rd_x_r, rd_z_r;
  logic [GEO_W-1:0] rd_g_r;

  logic [CFG_W-1:0] cfg_r;
  logic [SEG_CW-1:0] nseg, seg_r;
  logic [CELL_W-1:0] cell_r, n_r, rd_n;
  logic [SLEN_W-1:0] rd_len, len_r;
  logic [CLEN_W-1:0] cl_r;
  logic signed [COORD_W-1:0] sx_r, ex_r, sz_r, ez_r, px_r, pz_r, cx_r, cz_r;
  logic negx_r, negz_r;
  logic [PROD1_W-1:0] p1x_r, p1z_r;
  logic [NUM_W-1:0]   qx_r, qz_r;
  logic [DIV_W-1:0]   remx_r, remz_r;
  logic [DCNT_W-1:0]  dcnt_r;
  logic [SQ_W-1:0]    sqx_r, sqz_r;
  logic               have_r;
  logic [DIST_W-1:0]  best_d_r;
  logic [SLOT_W-1:0]  best_s_r;
  logic [CELL_W-1:0]  best_c_r;

  // Segment table
  always_ff @(posedge clk) begin
    if (cmd.load_wr && ({1'b0, in_segment_slot} < (SLOT_W+1)'(MAX_SEGMENTS))) begin
      mem_x[in_segment_slot[SEG_AW-1:0]] <= {in_end_x, in_start_x};
      mem_z[in_segment_slot[SEG_AW-1:0]] <= {in_end_z, in_start_z};
      mem_g[in_segment_slot[SEG_AW-1:0]] <= {1'b0, in_cell_total, in_segment_len, in_cell_len};
    end
    rd_x_r <= mem_x[seg_r[SEG_AW-1:0]];
    rd_z_r <= mem_z[seg_r[SEG_AW-1:0]];
    rd_g_r <= mem_g[seg_r[SEG_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) cfg_r <= '0;
    else if (cfg_we) cfg_r <= cfg_data;
  end

  assign nseg = ({1'b0, cfg_r} > (CFG_W+1)'(MAX_SEGMENTS)) ? SEG_CW'(MAX_SEGMENTS)
                                                          : SEG_CW'(cfg_r);
  assign rd_len = rd_g_r[CLEN_W +: SLEN_W];
  assign rd_n   = (rd_g_r[CLEN_W+SLEN_W +: CELL_W] > CELL_W'(MAX_CELLS)) ?
                  CELL_W'(MAX_CELLS) : rd_g_r[CLEN_W+SLEN_W +: CELL_W];

  assign st.nseg_zero    = (nseg == '0);
  assign st.rd_n_zero    = (rd_n == '0);
  assign st.rd_len_zero  = (rd_len == '0);
  assign st.seg_len_zero = (len_r == '0);
  assign st.last_seg     = (seg_r + SEG_CW'(1) == nseg);
  assign st.last_cell    = (cell_r + CELL_W'(1) == n_r);
  assign st.div_last     = (dcnt_r == '0);

  // Axis differences and magnitudes
  logic signed [DIFF_W-1:0] dxe, dze;
  logic [DIFF_W-1:0] magx, magz;
  logic [K_W-1:0]    k;
  assign dxe  = DIFF_W'(ex_r) - DIFF_W'(sx_r);
  assign dze  = DIFF_W'(ez_r) - DIFF_W'(sz_r);
  assign magx = dxe[DIFF_W-1] ? DIFF_W'(-dxe) : DIFF_W'(dxe);
  assign magz = dze[DIFF_W-1] ? DIFF_W'(-dze) : DIFF_W'(dze);
  assign k    = {cell_r, 1'b1};

  logic [PROD2_W-1:0] p2x, p2z;
  assign p2x = PROD2_W'(p1x_r) * PROD2_W'(cl_r);
  assign p2z = PROD2_W'(p1z_r) * PROD2_W'(cl_r);

  // Restoring divide step, divisor 2*len
  logic [DIV_W-1:0] dvs;
  logic [DIV_W:0]   shx, shz;
  logic             gex, gez;
  assign dvs = {len_r, 1'b0};
  assign shx = {remx_r, qx_r[NUM_W-1]};
  assign shz = {remz_r, qz_r[NUM_W-1]};
  assign gex = (shx >= {1'b0, dvs});
  assign gez = (shz >= {1'b0, dvs});

  function automatic logic signed [COORD_W-1:0] sat_center(
    input logic signed [COORD_W-1:0] from, input logic neg, input logic [NUM_W-1:0] q);
    logic signed [CEN_W-1:0] off, c;
    begin
      off = $signed({2'b00, q});
      if (neg) off = -off;
      c = CEN_W'(from) + off;
      if (c > CEN_W'(COORD_MAX))      sat_center = COORD_MAX;
      else if (c < CEN_W'(COORD_MIN)) sat_center = COORD_MIN;
      else                            sat_center = c[COORD_W-1:0];
    end
  endfunction

  logic signed [DIFF_W-1:0]   dpx, dpz;
  logic signed [2*DIFF_W-1:0] sqx_full, sqz_full;
  logic [DIST_W-1:0]          d2;
  assign dpx      = DIFF_W'(px_r) - DIFF_W'(cx_r);
  assign dpz      = DIFF_W'(pz_r) - DIFF_W'(cz_r);
  assign sqx_full = dpx * dpx;
  assign sqz_full = dpz * dpz;
  assign d2       = {1'b0, sqx_r} + {1'b0, sqz_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_r <= 1'b0;
      seg_r  <= '0;
    end else begin
      if (cmd.probe_ld) begin
        have_r <= 1'b0;
        seg_r  <= '0;
      end else if (cmd.seg_inc) begin
        seg_r <= seg_r + SEG_CW'(1);
      end
      if (cmd.cmp && (!have_r || d2 < best_d_r)) have_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.probe_ld) begin
      px_r     <= in_probe_x;
      pz_r     <= in_probe_z;
      best_s_r <= '0;
      best_c_r <= '0;
    end
    if (cmd.seg_ld) begin
      sx_r   <= rd_x_r[COORD_W-1:0];
      ex_r   <= rd_x_r[EP_W-1:COORD_W];
      sz_r   <= rd_z_r[COORD_W-1:0];
      ez_r   <= rd_z_r[EP_W-1:COORD_W];
      cl_r   <= rd_g_r[CLEN_W-1:0];
      len_r  <= rd_len;
      n_r    <= rd_n;
      cell_r <= '0;
    end else if (cmd.cell_inc) begin
      cell_r <= cell_r + CELL_W'(1);
    end
    if (cmd.zero_center) begin
      cx_r <= '0;
      cz_r <= '0;
    end
    if (cmd.mul1) begin
      p1x_r  <= PROD1_W'(magx) * PROD1_W'(k);
      p1z_r  <= PROD1_W'(magz) * PROD1_W'(k);
      negx_r <= dxe[DIFF_W-1];
      negz_r <= dze[DIFF_W-1];
    end
    if (cmd.mul2) begin
      qx_r   <= NUM_W'(p2x) + NUM_W'(len_r);
      qz_r   <= NUM_W'(p2z) + NUM_W'(len_r);
      remx_r <= '0;
      remz_r <= '0;
      dcnt_r <= DCNT_W'(DIV_STEPS - 1);
    end
    if (cmd.div_step) begin
      remx_r <= gex ? DIV_W'(shx - {1'b0, dvs}) : shx[DIV_W-1:0];
      remz_r <= gez ? DIV_W'(shz - {1'b0, dvs}) : shz[DIV_W-1:0];
      qx_r   <= {qx_r[NUM_W-2:0], gex};
      qz_r   <= {qz_r[NUM_W-2:0], gez};
      dcnt_r <= dcnt_r - DCNT_W'(1);
    end
    if (cmd.center) begin
      cx_r <= sat_center(sx_r, negx_r, qx_r);
      cz_r <= sat_center(sz_r, negz_r, qz_r);
    end
    if (cmd.sq) begin
      sqx_r <= sqx_full[SQ_W-1:0];
      sqz_r <= sqz_full[SQ_W-1:0];
    end
    if (cmd.cmp && (!have_r || d2 < best_d_r)) begin
      best_d_r <= d2;
      best_s_r <= seg_r[SLOT_W-1:0];
      best_c_r <= cell_r;
    end
    if (cmd.res_ld) begin
      out_found           <= have_r;
      out_best_segment    <= best_s_r;
      out_best_cell_index <= best_c_r;
    end
  end

endmodule
